/* hdl/clr_pkg.sv */
// clipped line rasterizer package: shared constants and types
// no dependencies
package clr_pkg;

  localparam int unsigned DefScreenWidth  = 512;
  localparam int unsigned DefScreenHeight = 256;
  localparam int unsigned FracBits        = 8;
  localparam int unsigned ClipRounds      = 16;

  localparam int unsigned CrdW = 16;   // input coordinate width
  localparam int unsigned RegW = 13;   // config register width
  localparam int unsigned WkW  = 18;   // working coordinate width (saturated to 17 bits + margin)
  localparam int unsigned DivW = 26;   // dividend magnitude width

  localparam logic [2:0] RegClipLeft   = 3'd0;
  localparam logic [2:0] RegClipTop    = 3'd1;
  localparam logic [2:0] RegClipRight  = 3'd2;
  localparam logic [2:0] RegClipBottom = 3'd3;
  localparam logic [2:0] RegRowPitch   = 3'd4;

  localparam logic OpLine = 1'b0;
  localparam logic OpTick = 1'b1;

  // region code bits
  localparam logic [3:0] CodeLeft   = 4'd1;
  localparam logic [3:0] CodeRight  = 4'd2;
  localparam logic [3:0] CodeTop    = 4'd4;
  localparam logic [3:0] CodeBottom = 4'd8;

  typedef struct packed {
    logic [RegW-1:0] left;
    logic [RegW-1:0] top;
    logic [RegW-1:0] right;
    logic [RegW-1:0] bottom;
    logic [RegW-1:0] pitch;
  } clip_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch endpoints, compute initial codes
    logic setup;     // latch edge choice and start divide operands
    logic div_step;  // one restoring divide bit
    logic mul;       // register delta*t product
    logic apply;     // write moved endpoint
    logic finish;    // clamp and set up stepper
    logic step;      // emit and advance stepper
  } clr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic codes_zero;
    logic codes_share;
    logic div_last;
    logic done_pix;
  } clr_sts_t;

endpackage

/* hdl/clr_ctrl.sv */
// clipped line rasterizer controller: sequences clip rounds and pixel stepping
// depends on clr_pkg
module clr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output clr_pkg::clr_cmd_t cmd,
  input  clr_pkg::clr_sts_t sts
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StApply = 3'd4;
  localparam logic [2:0] StFin   = 3'd5;
  localparam logic [2:0] StBusy  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [4:0] round_r, round_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       in_acc, out_free;

  assign out_free  = !ovalid_r || !out_stall;
  // commands and ticks accepted only in idle/busy and only when output slot can take a beat
  assign in_stall  = !((state_r == StIdle || state_r == StBusy) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    round_nxt  = round_r;
    ovalid_nxt = ovalid_r && out_stall;
    cmd        = '0;
    unique case (state_r)
      StIdle, StBusy: begin
        if (in_acc) begin
          if (in_op == clr_pkg::OpLine) begin
            cmd.load  = 1'b1;
            round_nxt = '0;
            state_nxt = StCheck;
          end else if (state_r == StBusy) begin
            cmd.step   = 1'b1;
            ovalid_nxt = 1'b1;
            if (sts.done_pix) state_nxt = StIdle;
          end
        end
      end
      StCheck: begin
        if (sts.codes_zero) state_nxt = StFin;
        else if (sts.codes_share) state_nxt = StIdle;
        else if (round_r == 5'(clr_pkg::ClipRounds)) state_nxt = StFin;
        else begin
          cmd.setup = 1'b1;
          state_nxt = StDiv;
        end
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = StMul;
      end
      StMul: begin
        cmd.mul   = 1'b1;
        state_nxt = StApply;
      end
      StApply: begin
        cmd.apply = 1'b1;
        round_nxt = round_r + 5'd1;
        state_nxt = StCheck;
      end
      StFin: begin
        cmd.finish = 1'b1;
        state_nxt  = StBusy;
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= StIdle;
      round_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      round_r  <= round_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

/* hdl/clr_dp.sv */
// clipped line rasterizer datapath: clip arithmetic, serial divider, stepper
// depends on clr_pkg
module clr_dp (
  input  logic                            clk,
  input  clr_pkg::clr_cmd_t               cmd,
  output clr_pkg::clr_sts_t               sts,
  input  clr_pkg::clip_cfg_t              cfg,
  input  logic signed [clr_pkg::CrdW-1:0] in_start_x,
  input  logic signed [clr_pkg::CrdW-1:0] in_start_y,
  input  logic signed [clr_pkg::CrdW-1:0] in_end_x,
  input  logic signed [clr_pkg::CrdW-1:0] in_end_y,
  input  logic [15:0]                     in_pixel_color,
  output logic [11:0]                     out_pixel_x,
  output logic [11:0]                     out_pixel_y,
  output logic [23:0]                     out_pixel_address,
  output logic [15:0]                     out_out_color,
  output logic                            out_last
);

  localparam int unsigned W  = clr_pkg::WkW;
  localparam int unsigned DW = clr_pkg::DivW;
  localparam int unsigned FB = clr_pkg::FracBits;
  localparam int unsigned CW = 5;

  typedef logic signed [W-1:0] crd_t;

  crd_t x1_r, y1_r, x2_r, y2_r;
  logic [3:0] f1_r, f2_r;
  logic [15:0] color_r;

  // clip round operands
  logic        edge_y_r;      // clipped axis is y
  logic        move1_r;
  crd_t        bound_r;
  logic [DW-1:0] rem_r, quo_r, dsr_r, num_r;
  logic        tneg_r;
  logic [CW-1:0] cnt_r;
  logic signed [DW+W:0] prod_r;
  crd_t        oth0_r;

  // stepper
  logic signed [13:0] cx_r, cy_r, tx_r, ty_r;
  logic signed [13:0] sx_r, sy_r;
  logic signed [15:0] err_r;
  logic               ydesc_r;

  function automatic logic [3:0] code_init(crd_t x, crd_t y, clr_pkg::clip_cfg_t c);
    logic [3:0] r;
    r = '0;
    if (x >= crd_t'({1'b0, c.right})) r = clr_pkg::CodeRight;
    else if (x < crd_t'({1'b0, c.left})) r = clr_pkg::CodeLeft;
    if (y >= crd_t'({1'b0, c.bottom})) r = r | clr_pkg::CodeBottom;
    else if (y < crd_t'({1'b0, c.top})) r = r | clr_pkg::CodeTop;
    return r;
  endfunction

  function automatic logic [3:0] code_moved(crd_t x, crd_t y, clr_pkg::clip_cfg_t c);
    logic [3:0] r;
    r = '0;
    if (x > crd_t'({1'b0, c.right})) r = clr_pkg::CodeRight;
    else if (x < crd_t'({1'b0, c.left})) r = clr_pkg::CodeLeft;
    if (y < crd_t'({1'b0, c.top})) r = r | clr_pkg::CodeTop;
    else if (y > crd_t'({1'b0, c.bottom})) r = r | clr_pkg::CodeBottom;
    return r;
  endfunction

  function automatic crd_t clamp(crd_t v, logic [clr_pkg::RegW-1:0] lo,
                                 logic [clr_pkg::RegW-1:0] hi);
    crd_t hm;
    hm = crd_t'({1'b0, hi}) - crd_t'(1);
    if (v > hm) return hm;
    if (v < crd_t'({1'b0, lo})) return crd_t'({1'b0, lo});
    return v;
  endfunction

  // edge selection
  logic [3:0] cf;
  logic       s_edge_y;
  crd_t       s_bound, s_from, s_to, s_o0, s_o1, s_div;
  logic signed [W+FB:0] s_num;
  logic [DW-1:0] s_nabs, s_dabs;
  always_comb begin
    cf = (f1_r != 4'd0) ? f1_r : f2_r;
    s_edge_y = 1'b1;
    priority if ((cf & clr_pkg::CodeBottom) != 4'd0) s_bound = crd_t'({1'b0, cfg.bottom});
    else if ((cf & clr_pkg::CodeTop) != 4'd0) s_bound = crd_t'({1'b0, cfg.top});
    else if ((cf & clr_pkg::CodeRight) != 4'd0) begin
      s_bound = crd_t'({1'b0, cfg.right}); s_edge_y = 1'b0;
    end else begin
      s_bound = crd_t'({1'b0, cfg.left}); s_edge_y = 1'b0;
    end
    s_from = s_edge_y ? y1_r : x1_r;
    s_to   = s_edge_y ? y2_r : x2_r;
    s_o0   = s_edge_y ? x1_r : y1_r;
    s_o1   = s_edge_y ? x2_r : y2_r;
    s_div  = (s_to == s_from) ? crd_t'(1) : s_to - s_from;
    s_num  = (W+FB+1)'(s_bound - s_from) <<< FB;
    s_nabs = s_num[W+FB] ? DW'(-s_num) : DW'(s_num);
    s_dabs = s_div[W-1] ? DW'(-s_div) : DW'(s_div);
  end

  // restoring divide, one quotient bit per cycle
  logic [DW:0] d_trial;
  logic [DW-1:0] d_rem_sh;
  assign d_rem_sh = {rem_r[DW-2:0], num_r[DW-1]};
  assign d_trial  = {1'b0, d_rem_sh} - {1'b0, dsr_r};

  // product and intersection
  logic signed [DW:0] t_s;
  logic signed [DW+W:0] prod_nxt;
  logic signed [DW+W:0] cross_v;
  crd_t cross_sat;
  assign t_s      = tneg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  always_comb begin
    prod_nxt  = (DW+W+1)'(s_o1 - s_o0) * (DW+W+1)'(t_s);
    cross_v   = (prod_r >>> FB) + (DW+W+1)'(oth0_r);
    if (cross_v > (DW+W+1)'(65535)) cross_sat = crd_t'(65535);
    else if (cross_v < -(DW+W+1)'(65536)) cross_sat = -crd_t'(65536);
    else cross_sat = crd_t'(cross_v);
  end

  crd_t nx, ny;
  assign nx = edge_y_r ? cross_sat : bound_r;
  assign ny = edge_y_r ? bound_r : cross_sat;

  // finish: clamp and stepper set-up
  crd_t cx1, cy1, cx2, cy2, adx, ady;
  logic signed [15:0] h0;
  always_comb begin
    cx1 = clamp(x1_r, cfg.left, cfg.right);
    cy1 = clamp(y1_r, cfg.top, cfg.bottom);
    cx2 = clamp(x2_r, cfg.left, cfg.right);
    cy2 = clamp(y2_r, cfg.top, cfg.bottom);
    adx = (cx2 < cx1) ? cx1 - cx2 : cx2 - cx1;
    ady = (cy2 < cy1) ? cy1 - cy2 : cy2 - cy1;
    if (adx <= ady) h0 = -16'((ady + crd_t'(3)) >>> 2);
    else h0 = 16'(adx >>> 2);
  end

  // stepper next
  logic done_w;
  logic signed [15:0] e1, e2;
  logic signed [13:0] nxx, nyy;
  always_comb begin
    if (ydesc_r) done_w = !(cx_r < tx_r || cy_r > ty_r);
    else done_w = !(cx_r < tx_r || cy_r < ty_r);
    e1 = err_r; nxx = cx_r; nyy = cy_r;
    if (e1 > -16'(sx_r)) begin
      e1 = e1 - 16'(sy_r); nxx = cx_r + 14'sd1;
    end
    e2 = e1;
    if (e1 < 16'(sy_r)) begin
      e2 = e1 + 16'(sx_r);
      nyy = ydesc_r ? cy_r - 14'sd1 : cy_r + 14'sd1;
    end
  end

  assign sts.codes_zero  = (f1_r | f2_r) == 4'd0;
  assign sts.codes_share = (f1_r & f2_r) != 4'd0;
  assign sts.div_last    = cnt_r == CW'(DW-1);
  assign sts.done_pix    = done_w;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1_r <= crd_t'(in_start_x); y1_r <= crd_t'(in_start_y);
      x2_r <= crd_t'(in_end_x);   y2_r <= crd_t'(in_end_y);
      f1_r <= code_init(crd_t'(in_start_x), crd_t'(in_start_y), cfg);
      f2_r <= code_init(crd_t'(in_end_x), crd_t'(in_end_y), cfg);
      color_r <= in_pixel_color;
    end
    if (cmd.setup) begin
      edge_y_r <= s_edge_y;
      move1_r  <= f1_r != 4'd0;
      bound_r  <= s_bound;
      num_r    <= s_nabs;
      dsr_r    <= s_dabs;
      rem_r    <= '0;
      quo_r    <= '0;
      cnt_r    <= '0;
      tneg_r   <= s_num[W+FB] ^ s_div[W-1];
      oth0_r   <= s_o0;
    end
    if (cmd.div_step) begin
      num_r <= num_r << 1;
      cnt_r <= cnt_r + CW'(1);
      if (!d_trial[DW]) begin
        rem_r <= d_trial[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= d_rem_sh;
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
    if (cmd.mul) prod_r <= prod_nxt;
    if (cmd.apply) begin
      if (move1_r) begin
        x1_r <= nx; y1_r <= ny; f1_r <= code_moved(nx, ny, cfg);
      end else begin
        x2_r <= nx; y2_r <= ny; f2_r <= code_moved(nx, ny, cfg);
      end
    end
    if (cmd.finish) begin
      if (cx2 < cx1) begin
        cx_r <= 14'(cx2); cy_r <= 14'(cy2); tx_r <= 14'(cx1); ty_r <= 14'(cy1);
        ydesc_r <= cy2 > cy1;
      end else begin
        cx_r <= 14'(cx1); cy_r <= 14'(cy1); tx_r <= 14'(cx2); ty_r <= 14'(cy2);
        ydesc_r <= cy1 > cy2;
      end
      sx_r  <= 14'(adx);
      sy_r  <= 14'(ady);
      err_r <= h0;
    end
    if (cmd.step) begin
      out_pixel_x       <= cx_r[11:0];
      out_pixel_y       <= cy_r[11:0];
      out_pixel_address <= 24'(cy_r) * 24'(cfg.pitch) + 24'(cx_r);
      out_out_color     <= color_r;
      out_last          <= done_w;
      if (!done_w) begin
        cx_r <= nxx; cy_r <= nyy; err_r <= e2;
      end
    end
  end

endmodule

/* hdl/clipped_line_rasterizer_top.sv */
// clipped line rasterizer top level: config registers, controller, datapath
// depends on clr_pkg, clr_ctrl, clr_dp
//
// A line command (in_op = 0) is clipped against the window by region codes;
// each clip round runs a bit-serial divider over the 26-bit dividend plus a
// multiply and an apply step, for up to 16 rounds, and the input is stalled
// meanwhile. Afterwards each tick beat (in_op = 1) yields one pixel beat per
// cycle while the output is not stalled; a tick while no line is active
// yields nothing. The output register frees for a new tick as it is taken.
module clipped_line_rasterizer_top #(
  parameter int unsigned SCREEN_WIDTH  = clr_pkg::DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = clr_pkg::DefScreenHeight
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  input  logic [15:0] in_pixel_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_pixel_x,
  output logic [11:0] out_pixel_y,
  output logic [23:0] out_pixel_address,
  output logic [15:0] out_out_color,
  output logic        out_last
);

  clr_pkg::clip_cfg_t cfg_r;
  clr_pkg::clr_cmd_t  cmd;
  clr_pkg::clr_sts_t  sts;

  // config registers, reset to full screen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left   <= '0;
      cfg_r.top    <= '0;
      cfg_r.right  <= 13'(SCREEN_WIDTH);
      cfg_r.bottom <= 13'(SCREEN_HEIGHT);
      cfg_r.pitch  <= 13'(SCREEN_WIDTH);
    end else if (cfg_we) begin
      unique case (cfg_index)
        clr_pkg::RegClipLeft:   cfg_r.left   <= cfg_data;
        clr_pkg::RegClipTop:    cfg_r.top    <= cfg_data;
        clr_pkg::RegClipRight:  cfg_r.right  <= cfg_data;
        clr_pkg::RegClipBottom: cfg_r.bottom <= cfg_data;
        clr_pkg::RegRowPitch:   cfg_r.pitch  <= cfg_data;
        default: ;
      endcase
    end
  end

  clr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_op, .in_stall,
    .out_valid, .out_stall, .cmd, .sts
  );

  clr_dp u_dp (
    .clk, .cmd, .sts, .cfg(cfg_r),
    .in_start_x, .in_start_y, .in_end_x, .in_end_y, .in_pixel_color,
    .out_pixel_x, .out_pixel_y, .out_pixel_address, .out_out_color, .out_last
  );

  // every stepper step produces a pixel beat
  a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> out_valid) else $error("step without output beat");
  // controller issues at most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("multiple datapath commands");
  // no input taken while clipping
  a_clip_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.setup || cmd.div_step || cmd.mul || cmd.apply) |-> in_stall)
    else $error("input accepted during clipping");

endmodule
